>>> rtl/core/nor_flash_command_interface_macros.svh
// Assertion macros shared by the flash command interface RTL.
`ifndef NOR_FLASH_COMMAND_INTERFACE_MACROS_SVH
`define NOR_FLASH_COMMAND_INTERFACE_MACROS_SVH
`ifndef SYNTHESIS
`define NFCI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define NFCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define NFCI_ASSERT_SAME(label, clk, rst, ante, cons)
`define NFCI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/nfci_pkg.sv
// ----------------------------------------------------------------------------
// nfci_pkg
// Types, command codes and the bottom-boot sector map of the flash model.
// ----------------------------------------------------------------------------
package nfci_pkg;

   localparam int WORD_ADDR_BITS_DEF = 19;
   localparam int SECTOR_COUNT_DEF   = 19;
   localparam int MAP_SIZE           = 19;
   localparam int SECT_IDX_BITS      = 5;
   localparam int OFF_BITS           = 20;
   localparam int OFF_WORD_BITS      = 19;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 19;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_BASE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAKER_ID     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PART_ID      = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROTECT_MASK = 2'd3;

   localparam logic [2:0] PH_READ     = 3'd0;
   localparam logic [2:0] PH_UNLOCK1  = 3'd1;
   localparam logic [2:0] PH_UNLOCK2  = 3'd2;
   localparam logic [2:0] PH_PROGRAM  = 3'd3;
   localparam logic [2:0] PH_ERASE    = 3'd4;
   localparam logic [2:0] PH_EUNLOCK1 = 3'd5;
   localparam logic [2:0] PH_EUNLOCK2 = 3'd6;
   localparam logic [2:0] PH_AUTO     = 3'd7;

   localparam logic [OFF_BITS-1:0] OFF_UNLOCK1 = 20'haaa;
   localparam logic [OFF_BITS-1:0] OFF_UNLOCK2 = 20'h554;
   localparam logic [15:0] DATA_UNLOCK1 = 16'haaaa;
   localparam logic [15:0] DATA_UNLOCK2 = 16'h5555;
   localparam logic [15:0] CMD_ERASE    = 16'h8080;
   localparam logic [15:0] CMD_PROGRAM  = 16'ha0a0;
   localparam logic [15:0] CMD_CONFIRM  = 16'h3030;
   localparam logic [15:0] CMD_AUTO     = 16'h9090;
   localparam logic [15:0] CMD_RESET    = 16'hf0f0;
   localparam logic [15:0] ERASED_WORD  = 16'hffff;

   localparam logic [1:0] AS_MAKER   = 2'd0;
   localparam logic [1:0] AS_PART    = 2'd1;
   localparam logic [1:0] AS_PROTECT = 2'd2;

   localparam logic [OFF_BITS-1:0] SECT_LO [MAP_SIZE] = '{
      20'h00000, 20'h04000, 20'h06000, 20'h08000, 20'h10000, 20'h20000, 20'h30000,
      20'h40000, 20'h50000, 20'h60000, 20'h70000, 20'h80000, 20'h90000, 20'ha0000,
      20'hb0000, 20'hc0000, 20'hd0000, 20'he0000, 20'hf0000};
   localparam logic [OFF_BITS-1:0] SECT_HI [MAP_SIZE] = '{
      20'h03fff, 20'h05fff, 20'h07fff, 20'h0ffff, 20'h1ffff, 20'h2ffff, 20'h3ffff,
      20'h4ffff, 20'h5ffff, 20'h6ffff, 20'h7ffff, 20'h8ffff, 20'h9ffff, 20'haffff,
      20'hbffff, 20'hcffff, 20'hdffff, 20'heffff, 20'hfffff};

   typedef struct packed {
      logic [3:0]  window_base;
      logic [7:0]  maker_id;
      logic [15:0] part_id;
      logic [MAP_SIZE-1:0] protect_mask;
   } nfci_csr_type;

   // One classified bus access, as queued between the front and back parts.
   typedef struct packed {
      logic                     is_write;
      logic                     in_window;
      logic [OFF_BITS-1:0]      offset;
      logic [15:0]              data;
      logic                     sect_ok;
      logic [SECT_IDX_BITS-1:0] sect_idx;
      logic                     prot;
   } nfci_item_type;

   function automatic logic [OFF_WORD_BITS-1:0] sect_first_word(
      input logic [SECT_IDX_BITS-1:0] idx);
      logic [OFF_BITS-1:0] lo;
      lo = '0;
      for (int i = 0; i < MAP_SIZE; i++) begin
         if (idx == SECT_IDX_BITS'(i)) lo = SECT_LO[i];
      end
      return lo[OFF_BITS-1:1];
   endfunction

   function automatic logic [OFF_WORD_BITS-1:0] sect_last_word(
      input logic [SECT_IDX_BITS-1:0] idx);
      logic [OFF_BITS-1:0] hi;
      hi = '0;
      for (int i = 0; i < MAP_SIZE; i++) begin
         if (idx == SECT_IDX_BITS'(i)) hi = SECT_HI[i];
      end
      return hi[OFF_BITS-1:1];
   endfunction

endpackage

>>> rtl/core/nfci_if.sv
// ----------------------------------------------------------------------------
// nfci_req_if / nfci_rsp_if
// Valid/ready channels for bus accesses and their results.
// ----------------------------------------------------------------------------
interface nfci_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [23:0] bus_address;
   logic [15:0] write_data;
   modport source (output valid, mode, bus_address, write_data, input ready);
   modport sink   (input valid, mode, bus_address, write_data, output ready);
endinterface

interface nfci_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        out_of_window;
   logic        sequence_broken;
   logic [2:0]  command_phase;
   modport source (output valid, read_data, out_of_window, sequence_broken,
                   command_phase, input ready);
   modport sink   (input valid, read_data, out_of_window, sequence_broken,
                   command_phase, output ready);
endinterface

>>> rtl/core/nor_flash_command_interface.sv
// ----------------------------------------------------------------------------
// nor_flash_command_interface
// 16-bit bottom-boot NOR flash command set: unlock, program, erase, autoselect.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req_ch   in         mode, bus_address, write_data
// rsp_ch   out        read_data, out_of_window, sequence_broken, command_phase
// csr_*    in         window_base, maker_id, part_id, protect_mask writes
//
// In the back state machine an array read passes execute, read-wait and done;
// a plain write passes execute and done; a program adds a write step for the
// read-modify-write on the array port. A sector erase sets every word of the
// sector (up to 32768) to all ones. After reset the array is swept to all
// ones before any item is executed; items queue meanwhile. Results wait in an
// output register, and two accepted items can wait in the queue.
module nor_flash_command_interface #(
   parameter int WORD_ADDR_BITS = nfci_pkg::WORD_ADDR_BITS_DEF,
   parameter int SECTOR_COUNT   = nfci_pkg::SECTOR_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   nfci_req_if.sink                            req_ch,
   nfci_rsp_if.source                          rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [nfci_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nfci_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   nfci_pkg::nfci_csr_type csr_ff, csr_in;
   nfci_pkg::nfci_item_type head;
   logic not_empty;
   logic pop;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            nfci_pkg::CSR_WINDOW_BASE:  csr_in.window_base  = csr_write_data[3:0];
            nfci_pkg::CSR_MAKER_ID:     csr_in.maker_id     = csr_write_data[7:0];
            nfci_pkg::CSR_PART_ID:      csr_in.part_id      = csr_write_data[15:0];
            nfci_pkg::CSR_PROTECT_MASK: csr_in.protect_mask = csr_write_data;
            default:                    csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.window_base  <= 4'd0;
         csr_ff.maker_id     <= 8'd1;
         csr_ff.part_id      <= 16'd8795;
         csr_ff.protect_mask <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   nfci_front #(.SECTOR_COUNT(SECTOR_COUNT)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr       (csr_ff),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   nfci_back #(.WORD_ADDR_BITS(WORD_ADDR_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );
endmodule

>>> rtl/core/nfci_ram.sv
// ----------------------------------------------------------------------------
// nfci_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module nfci_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/core/nfci_fifo.sv
// ----------------------------------------------------------------------------
// nfci_fifo
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module nfci_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  nfci_pkg::nfci_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output nfci_pkg::nfci_item_type head
);
   nfci_pkg::nfci_item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end
endmodule

>>> rtl/core/nfci_front.sv
// ----------------------------------------------------------------------------
// nfci_front
// Accepts bus accesses, checks the window and finds the sector and its lock.
// ----------------------------------------------------------------------------
module nfci_front #(
   parameter int SECTOR_COUNT = nfci_pkg::SECTOR_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   nfci_req_if.sink                req_ch,
   input  nfci_pkg::nfci_csr_type  csr,
   input  logic                    pop,
   output logic                    not_empty,
   output nfci_pkg::nfci_item_type head
);
   nfci_pkg::nfci_item_type item;
   logic full;
   logic push;

   always_comb begin
      item           = '0;
      item.is_write  = req_ch.mode;
      item.in_window = (req_ch.bus_address[23:20] == csr.window_base);
      item.offset    = req_ch.bus_address[19:0];
      item.data      = req_ch.write_data;
      for (int i = 0; i < SECTOR_COUNT; i++) begin
         if (item.offset >= nfci_pkg::SECT_LO[i] && item.offset <= nfci_pkg::SECT_HI[i]) begin
            item.sect_ok  = 1'b1;
            item.sect_idx = nfci_pkg::SECT_IDX_BITS'(i);
         end
      end
      item.prot = item.sect_ok & csr.protect_mask[item.sect_idx];
   end

   assign req_ch.ready = !full;
   assign push         = req_ch.valid && !full;

   nfci_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );
endmodule

>>> rtl/core/nfci_back.sv
// ----------------------------------------------------------------------------
// nfci_back
// Runs the command state machine against the array and drives results.
// ----------------------------------------------------------------------------
`include "nor_flash_command_interface_macros.svh"
module nfci_back #(
   parameter int WORD_ADDR_BITS = nfci_pkg::WORD_ADDR_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nfci_pkg::nfci_csr_type  csr,
   input  logic                    not_empty,
   input  nfci_pkg::nfci_item_type head,
   output logic                    pop,
   nfci_rsp_if.source              rsp_ch
);
   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_EXEC, ST_RDWAIT, ST_PROGWR, ST_ERASE, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   nfci_pkg::nfci_item_type cur_ff, cur_in;
   logic [nfci_pkg::OFF_WORD_BITS-1:0] cnt_ff, cnt_in;
   logic [15:0] res_rd_ff, res_rd_in;
   logic res_oow_ff, res_oow_in, res_brk_ff, res_brk_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_rd_ff, rsp_rd_in;
   logic rsp_oow_ff, rsp_oow_in, rsp_brk_ff, rsp_brk_in;
   logic [2:0] rsp_phase_ff, rsp_phase_in;

   logic ram_we;
   logic [WORD_ADDR_BITS-1:0] ram_addr;
   logic [15:0] ram_wdata, ram_rdata;
   logic [WORD_ADDR_BITS-1:0] widx;
   logic ok;
   logic [2:0] ok_phase;

   assign widx = cur_ff.offset[WORD_ADDR_BITS:1];

   nfci_ram #(.WIDTH(16), .DEPTH(2 ** WORD_ADDR_BITS)) u_array (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      res_rd_in = res_rd_ff;
      res_oow_in = res_oow_ff;
      res_brk_in = res_brk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_rd_in    = rsp_rd_ff;
      rsp_oow_in   = rsp_oow_ff;
      rsp_brk_in   = rsp_brk_ff;
      rsp_phase_in = rsp_phase_ff;
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = widx;
      ram_wdata = nfci_pkg::ERASED_WORD;
      ok        = 1'b0;
      ok_phase  = nfci_pkg::PH_READ;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = cnt_ff[WORD_ADDR_BITS-1:0];
            cnt_in   = cnt_ff + 1'b1;
            if (&cnt_ff[WORD_ADDR_BITS-1:0]) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (not_empty) begin
               pop      = 1'b1;
               cur_in   = head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_rd_in  = '0;
            res_oow_in = 1'b0;
            res_brk_in = 1'b0;
            state_in   = ST_DONE;
            if (!cur_ff.in_window) begin
               res_oow_in = 1'b1;
            end else if (!cur_ff.is_write) begin
               if (phase_ff == nfci_pkg::PH_AUTO) begin
                  case (cur_ff.offset[2:1])
                     nfci_pkg::AS_MAKER:   res_rd_in = {8'd0, csr.maker_id};
                     nfci_pkg::AS_PART:    res_rd_in = csr.part_id;
                     nfci_pkg::AS_PROTECT: res_rd_in = {15'd0, cur_ff.prot};
                     default:              res_rd_in = '0;
                  endcase
               end else begin
                  state_in = ST_RDWAIT;
               end
            end else if (phase_ff == nfci_pkg::PH_PROGRAM) begin
               phase_in = nfci_pkg::PH_READ;
               state_in = ST_PROGWR;
            end else if (cur_ff.data == nfci_pkg::CMD_RESET) begin
               phase_in = nfci_pkg::PH_READ;
            end else begin
               case (phase_ff) inside
                  nfci_pkg::PH_READ, nfci_pkg::PH_ERASE: begin
                     ok = cur_ff.offset == nfci_pkg::OFF_UNLOCK1 &&
                          cur_ff.data == nfci_pkg::DATA_UNLOCK1;
                     ok_phase = phase_ff + 3'd1;
                  end
                  nfci_pkg::PH_UNLOCK1, nfci_pkg::PH_EUNLOCK1: begin
                     ok = cur_ff.offset == nfci_pkg::OFF_UNLOCK2 &&
                          cur_ff.data == nfci_pkg::DATA_UNLOCK2;
                     ok_phase = phase_ff + 3'd1;
                  end
                  nfci_pkg::PH_UNLOCK2: begin
                     if (cur_ff.offset == nfci_pkg::OFF_UNLOCK1) begin
                        if (cur_ff.data == nfci_pkg::CMD_PROGRAM) begin
                           ok = 1'b1;
                           ok_phase = nfci_pkg::PH_PROGRAM;
                        end else if (cur_ff.data == nfci_pkg::CMD_ERASE) begin
                           ok = 1'b1;
                           ok_phase = nfci_pkg::PH_ERASE;
                        end else if (cur_ff.data == nfci_pkg::CMD_AUTO) begin
                           ok = 1'b1;
                           ok_phase = nfci_pkg::PH_AUTO;
                        end
                     end
                  end
                  nfci_pkg::PH_EUNLOCK2: begin
                     if (cur_ff.data == nfci_pkg::CMD_CONFIRM) begin
                        ok = 1'b1;
                        if (cur_ff.sect_ok && !cur_ff.prot) begin
                           cnt_in   = nfci_pkg::sect_first_word(cur_ff.sect_idx);
                           state_in = ST_ERASE;
                        end
                     end
                  end
                  default: ok = 1'b0;
               endcase
               if (ok) begin
                  phase_in = ok_phase;
               end else begin
                  res_brk_in = 1'b1;
                  if (phase_ff != nfci_pkg::PH_AUTO) phase_in = nfci_pkg::PH_READ;
               end
            end
         end
         ST_RDWAIT: begin
            res_rd_in = ram_rdata;
            state_in  = ST_DONE;
         end
         ST_PROGWR: begin
            // The read issued in the execute step returns the old word here.
            ram_we    = !cur_ff.prot;
            ram_wdata = ram_rdata & cur_ff.data;
            state_in  = ST_DONE;
         end
         ST_ERASE: begin
            ram_we   = 1'b1;
            ram_addr = cnt_ff[WORD_ADDR_BITS-1:0];
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == nfci_pkg::sect_last_word(cur_ff.sect_idx)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = res_rd_ff;
               rsp_oow_in   = res_oow_ff;
               rsp_brk_in   = res_brk_ff;
               rsp_phase_in = phase_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= nfci_pkg::PH_READ;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      res_rd_ff    <= res_rd_in;
      res_oow_ff   <= res_oow_in;
      res_brk_ff   <= res_brk_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_oow_ff   <= rsp_oow_in;
      rsp_brk_ff   <= rsp_brk_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.read_data       = rsp_rd_ff;
   assign rsp_ch.out_of_window   = rsp_oow_ff;
   assign rsp_ch.sequence_broken = rsp_brk_ff;
   assign rsp_ch.command_phase   = rsp_phase_ff;

   `NFCI_ASSERT_SAME(a_erase_writes_ones, clock, reset, state_ff == ST_ERASE,
      ram_we && ram_wdata == nfci_pkg::ERASED_WORD)
   `NFCI_ASSERT_NEXT(a_oow_keeps_phase, clock, reset,
      state_ff == ST_EXEC && !cur_ff.in_window,
      state_ff == ST_DONE && phase_ff == $past(phase_ff))
   `NFCI_ASSERT_SAME(a_oow_result_clean, clock, reset, rsp_valid_ff && rsp_oow_ff,
      !rsp_brk_ff && rsp_rd_ff == 16'd0)
   `NFCI_ASSERT_SAME(a_no_pop_in_clear, clock, reset, state_ff == ST_CLEAR, !pop)
endmodule
